// ===== rtl/core/efcd_pkg.sv =====
// Shared types and constants for the escaped frame / console demux.
// Used by efcd_parse and escaped_frame_console_demux; no dependencies.
package efcd_pkg;

  // Result status codes
  localparam logic [2:0] ST_CONSUMED = 3'd0;
  localparam logic [2:0] ST_PACKET   = 3'd1;
  localparam logic [2:0] ST_CHK_FAIL = 3'd2;
  localparam logic [2:0] ST_NOOP     = 3'd3;
  localparam logic [2:0] ST_CONSOLE  = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // Operation codes
  localparam logic OP_RX  = 1'b0;
  localparam logic OP_POP = 1'b1;

  // Configuration register indexes
  localparam logic [7:0] REG_ESCAPE = 8'd0;
  localparam logic [7:0] REG_TAG    = 8'd1;
  localparam logic [7:0] REG_SEED   = 8'd2;
  localparam logic [7:0] REG_IDLE   = 8'd3;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  console_byte;
    logic [7:0]  packet_type;
    logic [31:0] packet_payload;
    logic [1:0]  dropped_bytes;
  } out_t;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0] escape_code;
    logic [7:0] tag_code;
    logic [7:0] check_seed;
    logic [7:0] idle_type;
  } cfg_t;

  // Console pushes requested by the parser (push1 only with push0)
  typedef struct packed {
    logic       push0;
    logic       push1;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } push_t;

  // Frame outcome for one received byte
  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  ptype;
    logic [31:0] payload;
  } frm_t;

  typedef enum logic [2:0] {
    PH_TEXT = 3'b001,
    PH_ESC  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

endpackage

// ===== rtl/core/efcd_parse.sv =====
// Frame parser: escape/tag detection, frame body capture and running XOR check.
// Depends on efcd_pkg.
module efcd_parse #(
  parameter int FRAME_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  efcd_pkg::cfg_t      cfg,
  output efcd_pkg::push_t     push,
  output efcd_pkg::frm_t      frm
);

  localparam logic [4:0] BodyLen = 5'(FRAME_BYTES - 2);

  efcd_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  count_r, count_nxt;
  logic [7:0]  check_r, check_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] pay_r, pay_nxt;
  logic        last;

  assign last = (5'(count_r) + 5'd1) >= BodyLen;

  // Next-state and outputs for one received byte
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    check_nxt   = check_r;
    type_nxt    = type_r;
    pay_nxt     = pay_r;
    push        = '0;
    frm         = '0;
    frm.status  = efcd_pkg::ST_CONSUMED;
    case (phase_r)
      efcd_pkg::PH_TEXT: begin
        if (rx_byte == cfg.escape_code) begin
          phase_nxt = efcd_pkg::PH_ESC;
        end else begin
          push.push0 = 1'b1;
          push.byte0 = rx_byte;
        end
      end
      efcd_pkg::PH_ESC: begin
        // tag compare wins even when tag equals escape
        if (rx_byte == cfg.tag_code) begin
          phase_nxt = efcd_pkg::PH_BODY;
          count_nxt = '0;
          check_nxt = cfg.check_seed;
          type_nxt  = '0;
          pay_nxt   = '0;
        end else begin
          push.push0 = 1'b1;
          push.byte0 = cfg.escape_code;
          if (rx_byte != cfg.escape_code) begin
            push.push1 = 1'b1;
            push.byte1 = rx_byte;
            phase_nxt  = efcd_pkg::PH_TEXT;
          end
        end
      end
      default: begin
        // frame body
        if (last) begin
          phase_nxt   = efcd_pkg::PH_TEXT;
          count_nxt   = '0;
          frm.ptype   = type_r;
          frm.payload = pay_r;
          if (check_r != rx_byte) begin
            frm.status = efcd_pkg::ST_CHK_FAIL;
          end else if (type_r == cfg.idle_type) begin
            frm.status = efcd_pkg::ST_NOOP;
          end else begin
            frm.status = efcd_pkg::ST_PACKET;
          end
        end else begin
          case (count_r)
            4'd0:    type_nxt       = rx_byte;
            4'd1:    pay_nxt[7:0]   = rx_byte;
            4'd2:    pay_nxt[15:8]  = rx_byte;
            4'd3:    pay_nxt[23:16] = rx_byte;
            4'd4:    pay_nxt[31:24] = rx_byte;
            default: ;
          endcase
          check_nxt = check_r ^ rx_byte;
          count_nxt = count_r + 4'd1;
        end
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= efcd_pkg::PH_TEXT;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  // Frame payload registers, seeded at frame open and updated per body byte
  always_ff @(posedge clk) begin
    if (step) begin
      check_r <= check_nxt;
      type_r  <= type_nxt;
      pay_r   <= pay_nxt;
    end
  end

endmodule

// ===== rtl/core/escaped_frame_console_demux.sv =====
// Top level: config registers, console ring memory, result pipeline.
// Two registers (ring read, output reg) lie between input transaction and result valid.
// One transaction per cycle unless the output stalls; an escape not followed by the
// tag stalls the next transaction while its second console byte is written, when both
// of its bytes fit (single ring write port). Pops read the ring RAM's registered port.
// Reset (rst_n low, synchronous): clears parser phase, ring pointers, config
// registers and valids; ring contents are not cleared and need no sweep.
module escaped_frame_console_demux #(
  parameter int RING_DEPTH  = 64,
  parameter int FRAME_BYTES = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  efcd_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output efcd_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_index,
  input  logic [7:0]     cfg_data
);

  localparam int PtrW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(RING_DEPTH - 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  // Configuration registers
  efcd_pkg::cfg_t cfg_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        efcd_pkg::REG_ESCAPE: cfg_r.escape_code <= cfg_data;
        efcd_pkg::REG_TAG:    cfg_r.tag_code    <= cfg_data;
        efcd_pkg::REG_SEED:   cfg_r.check_seed  <= cfg_data;
        efcd_pkg::REG_IDLE:   cfg_r.idle_type   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control
  logic           acc_in;
  logic           s1_v_r;
  logic           s1_pop_r;
  efcd_pkg::out_t s1_res_r, s1_res_nxt;
  logic           s1_move;
  logic           out_v_r;
  efcd_pkg::out_t out_r;
  logic           wr_pend_r;
  logic [PtrW-1:0] pend_addr_r;
  logic [7:0]      pend_data_r;

  assign s1_move  = !out_v_r || out_ready;
  assign in_ready = !wr_pend_r && (!s1_v_r || s1_move);
  assign acc_in   = in_valid && in_ready;

  // Parser
  efcd_pkg::push_t push;
  efcd_pkg::frm_t  frm;

  efcd_parse #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (acc_in && (in_data.op == efcd_pkg::OP_RX)),
    .rx_byte(in_data.rx_byte),
    .cfg    (cfg_r),
    .push   (push),
    .frm    (frm)
  );

  // Ring pointers, push and pop decisions
  logic [PtrW-1:0] head_r, head_nxt, tail_r, tail_nxt, head_p1, head_p2;
  logic            empty, rd_en, ok0, ok1, is_rx;

  assign head_p1 = ptr_inc(head_r);
  assign head_p2 = ptr_inc(head_p1);
  assign empty   = (head_r == tail_r);
  assign is_rx   = (in_data.op == efcd_pkg::OP_RX);
  assign rd_en   = acc_in && !is_rx && !empty;
  // a dropped first byte means full, so the second drops as well
  assign ok0     = acc_in && is_rx && push.push0 && (head_p1 != tail_r);
  assign ok1     = ok0 && push.push1 && (head_p2 != tail_r);

  always_comb begin
    head_nxt = head_r;
    if (ok1) begin
      head_nxt = head_p2;
    end else if (ok0) begin
      head_nxt = head_p1;
    end
    tail_nxt = rd_en ? ptr_inc(tail_r) : tail_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      wr_pend_r <= ok1;
    end
  end

  // Second byte of a double push, written the following cycle
  always_ff @(posedge clk) begin
    if (ok1) begin
      pend_addr_r <= head_p1;
      pend_data_r <= push.byte1;
    end
  end

  // Console ring memory: one write port, one registered read port
  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      ring_mem[pend_addr_r] <= pend_data_r;
    end else if (ok0) begin
      ring_mem[head_r] <= push.byte0;
    end
    if (rd_en) begin
      rd_q_r <= ring_mem[tail_r];
    end
  end

  // Stage 1 result, console byte joins from the RAM read
  always_comb begin
    s1_res_nxt = '0;
    if (!is_rx) begin
      s1_res_nxt.status = empty ? efcd_pkg::ST_EMPTY : efcd_pkg::ST_CONSOLE;
    end else begin
      s1_res_nxt.status         = frm.status;
      s1_res_nxt.packet_type    = frm.ptype;
      s1_res_nxt.packet_payload = frm.payload;
      s1_res_nxt.dropped_bytes  = 2'(push.push0 && !ok0) + 2'(push.push1 && !ok1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc_in) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      s1_res_r <= s1_res_nxt;
      s1_pop_r <= rd_en;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_move) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_v_r) begin
      out_r              <= s1_res_r;
      out_r.console_byte <= s1_pop_r ? rd_q_r : 8'd0;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Assertions
  a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |=> !wr_pend_r)
    else $error("pending ring write lasted more than one cycle");

  a_pend_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> !acc_in)
    else $error("transaction accepted while a ring write is pending");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_move) |=> (s1_v_r && $stable(s1_res_r)))
    else $error("stage 1 result lost while output stalled");

  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_pop_r) |-> (s1_res_r.status == efcd_pkg::ST_CONSOLE &&
                              s1_res_r.dropped_bytes == 2'd0))
    else $error("ring read without console status");

endmodule
